// ===== hdl/cdeq_pkg.sv =====
// ----------------------------------------------------------------------------
// cdeq_pkg: shared definitions for the character deque
// Field widths, command and status codes, and the controller-to-datapath
// command bundle.
// ----------------------------------------------------------------------------
package cdeq_pkg;

  localparam int unsigned DEPTH_DEFAULT = 16;

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  localparam int unsigned IN_W  = CMD_W + CHAR_W;
  localparam int unsigned OUT_W = STATUS_W + 2 * CHAR_W + COUNT_W + 1;
  // Stream data is padded to whole bytes.
  localparam int unsigned IN_TDATA_W  = ((IN_W + 7) / 8) * 8;
  localparam int unsigned OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_CLEAR      = 3'd4,
    CMD_PEEK       = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Per-cycle commands from the controller to the datapath.
  typedef struct packed {
    logic take_cmd;  // capture the incoming request
    logic update;    // apply the command to pointers and storage
    logic read;      // read the front and back slots
    logic load_out;  // move the result into the output register
  } dp_cmd_t;

endpackage

// ===== hdl/cdeq_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdeq_ctrl: sequencing controller for the character deque
// Walks each request through update, read and output load, and owns the
// handshake flags of both stream sides.
// ----------------------------------------------------------------------------
module cdeq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_tvalid_i,
  output logic               s_tready_o,
  output logic               m_tvalid_o,
  input  logic               m_tready_i,
  output cdeq_pkg::dp_cmd_t  dp_cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_READ,
    S_LOAD
  } state_e;

  state_e state_q;
  logic   s_tready_q;
  logic   m_tvalid_q;
  logic   out_free;

  // The output register can take a result when it is empty or being drained.
  assign out_free = !m_tvalid_q || m_tready_i;

  always_comb begin
    dp_cmd_o.take_cmd = s_tvalid_i && s_tready_q;
    dp_cmd_o.update   = (state_q == S_UPDATE);
    dp_cmd_o.read     = (state_q == S_READ);
    dp_cmd_o.load_out = (state_q == S_LOAD) && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      s_tready_q <= 1'b1;
      m_tvalid_q <= 1'b0;
    end else begin
      // A drained result is replaced directly when a new one loads.
      if (m_tvalid_q && m_tready_i && !dp_cmd_o.load_out) begin
        m_tvalid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_tvalid_i && s_tready_q) begin
            state_q    <= S_UPDATE;
            s_tready_q <= 1'b0;
          end
        end
        S_UPDATE: begin
          state_q <= S_READ;
        end
        S_READ: begin
          state_q <= S_LOAD;
        end
        S_LOAD: begin
          if (out_free) begin
            state_q    <= S_IDLE;
            s_tready_q <= 1'b1;
            m_tvalid_q <= 1'b1;
          end
        end
        default: begin
          state_q    <= S_IDLE;
          s_tready_q <= 1'b1;
        end
      endcase
    end
  end

  assign s_tready_o = s_tready_q;
  assign m_tvalid_o = m_tvalid_q;

endmodule

// ===== hdl/cdeq_dpath.sv =====
// ----------------------------------------------------------------------------
// cdeq_dpath: datapath of the character deque
// Ring buffer storage, head index and fill count, and the result register.
// ----------------------------------------------------------------------------
module cdeq_dpath #(
  parameter int unsigned DEPTH = cdeq_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cdeq_pkg::dp_cmd_t                 dp_cmd_i,
  input  logic [cdeq_pkg::CMD_W-1:0]        command_i,
  input  logic [cdeq_pkg::CHAR_W-1:0]       char_in_i,
  output logic [cdeq_pkg::STATUS_W-1:0]     status_o,
  output logic [cdeq_pkg::CHAR_W-1:0]       front_char_o,
  output logic [cdeq_pkg::CHAR_W-1:0]       back_char_o,
  output logic [cdeq_pkg::COUNT_W-1:0]      count_o,
  output logic                              is_empty_o
);

  localparam int unsigned IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned SUM_W = IDX_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(DEPTH);

  // Adds an offset below DEPTH to an index and wraps once.
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] idx,
                                                input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(idx) + SUM_W'(off);
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    return sum[IDX_W-1:0];
  endfunction

  logic [cdeq_pkg::CHAR_W-1:0] slots_q [DEPTH];

  logic [cdeq_pkg::CMD_W-1:0]    cmd_q;
  logic [cdeq_pkg::CHAR_W-1:0]   char_q;
  logic [IDX_W-1:0]              head_q, head_d;
  logic [CNT_W-1:0]              fill_q, fill_d;
  logic [cdeq_pkg::STATUS_W-1:0] status_q, status_d;
  logic [cdeq_pkg::CHAR_W-1:0]   front_rd_q, back_rd_q;

  logic [cdeq_pkg::STATUS_W-1:0] status_out_q;
  logic [cdeq_pkg::CHAR_W-1:0]   front_out_q, back_out_q;
  logic [cdeq_pkg::COUNT_W-1:0]  count_out_q;
  logic                          empty_out_q;

  logic                          wr_en;
  logic [IDX_W-1:0]              wr_addr;
  logic [IDX_W-1:0]              head_dec;
  logic [CNT_W-1:0]              back_off;
  logic [IDX_W-1:0]              rd_back_addr;
  logic                          is_full, is_empty;

  assign is_full  = (fill_q == FULL_CNT);
  assign is_empty = (fill_q == '0);
  assign head_dec = (head_q == '0) ? LAST_IDX : head_q - 1'b1;

  always_comb begin
    head_d   = head_q;
    fill_d   = fill_q;
    status_d = cdeq_pkg::ST_OK;
    wr_en    = 1'b0;
    wr_addr  = head_dec;
    case (cmd_q)
      cdeq_pkg::CMD_PUSH_FRONT: begin
        if (is_full) begin
          status_d = cdeq_pkg::ST_FULL;
        end else begin
          head_d = head_dec;
          fill_d = fill_q + 1'b1;
          wr_en  = 1'b1;
        end
      end
      cdeq_pkg::CMD_PUSH_BACK: begin
        wr_addr = wrap_add(head_q, fill_q);
        if (is_full) begin
          status_d = cdeq_pkg::ST_FULL;
        end else begin
          fill_d = fill_q + 1'b1;
          wr_en  = 1'b1;
        end
      end
      cdeq_pkg::CMD_POP_FRONT: begin
        if (is_empty) begin
          status_d = cdeq_pkg::ST_EMPTY;
        end else begin
          head_d = (head_q == LAST_IDX) ? '0 : head_q + 1'b1;
          fill_d = fill_q - 1'b1;
        end
      end
      cdeq_pkg::CMD_POP_BACK: begin
        if (is_empty) begin
          status_d = cdeq_pkg::ST_EMPTY;
        end else begin
          fill_d = fill_q - 1'b1;
        end
      end
      cdeq_pkg::CMD_CLEAR: begin
        head_d = '0;
        fill_d = '0;
      end
      default: begin
        // Peek, and the unused codes that behave as peek.
        if (is_empty) begin
          status_d = cdeq_pkg::ST_EMPTY;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      fill_q <= '0;
    end else if (dp_cmd_i.update) begin
      head_q <= head_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.take_cmd) begin
      cmd_q  <= command_i;
      char_q <= char_in_i;
    end
    if (dp_cmd_i.update) begin
      status_q <= status_d;
    end
  end

  // Storage: one write port, two registered read ports.
  assign back_off     = is_empty ? '0 : fill_q - 1'b1;
  assign rd_back_addr = wrap_add(head_q, back_off);

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.update && wr_en) begin
      slots_q[wr_addr] <= char_q;
    end
    if (dp_cmd_i.read) begin
      front_rd_q <= slots_q[head_q];
      back_rd_q  <= slots_q[rd_back_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.load_out) begin
      status_out_q <= status_q;
      front_out_q  <= is_empty ? '0 : front_rd_q;
      back_out_q   <= is_empty ? '0 : back_rd_q;
      count_out_q  <= cdeq_pkg::COUNT_W'(fill_q);
      empty_out_q  <= is_empty;
    end
  end

  assign status_o     = status_out_q;
  assign front_char_o = front_out_q;
  assign back_char_o  = back_out_q;
  assign count_o      = count_out_q;
  assign is_empty_o   = empty_out_q;

endmodule

// ===== hdl/char_double_ended_queue_top.sv =====
// ----------------------------------------------------------------------------
// char_double_ended_queue_top: double-ended queue of 8-bit characters
// Ring buffer deque driven by one command per request on a stream input,
// answering every command with one status request on a stream output.
// ----------------------------------------------------------------------------
// Usage:
// Each request on the slave stream carries one command (push front, push
// back, pop front, pop back, clear or peek) and a character used by pushes.
// Every command yields exactly one request on the master stream with the
// status, the characters at both ends, the fill count and an empty flag.
// Commands are handled one at a time: a new command is not taken until the
// previous one has been applied to the pointers and storage, the storage
// has been read and the result has entered the output register, raising
// tvalid on the master side. The three-step walk through the controller,
// paced by the registered read of the slot storage, sets the command rate.
// When the receiver stalls, the result waits in the output register and
// the block still takes and processes one further command; that command's
// result is held until the output register drains.
// Reset empties the deque and the output register. Slot contents are not
// cleared; only slots that were pushed are ever shown.
// ----------------------------------------------------------------------------
module char_double_ended_queue_top #(
  parameter int unsigned DEPTH = cdeq_pkg::DEPTH_DEFAULT
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // Fields from bit 0 up: command (3), char_in (8), zero padding.
  input  logic [cdeq_pkg::IN_TDATA_W-1:0]      s_axis_tdata_i,
  output logic                                 m_axis_tvalid_o,
  input  logic                                 m_axis_tready_i,
  // Fields from bit 0 up: status (2), front_char (8), back_char (8),
  // count (5), is_empty (1).
  output logic [cdeq_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o
);

  localparam int unsigned CMD_LO   = 0;
  localparam int unsigned CHAR_LO  = CMD_LO + cdeq_pkg::CMD_W;
  localparam int unsigned ST_LO    = 0;
  localparam int unsigned FRONT_LO = ST_LO + cdeq_pkg::STATUS_W;
  localparam int unsigned BACK_LO  = FRONT_LO + cdeq_pkg::CHAR_W;
  localparam int unsigned COUNT_LO = BACK_LO + cdeq_pkg::CHAR_W;
  localparam int unsigned EMPTY_LO = COUNT_LO + cdeq_pkg::COUNT_W;

  cdeq_pkg::dp_cmd_t              dp_cmd;
  logic [cdeq_pkg::STATUS_W-1:0]  status;
  logic [cdeq_pkg::CHAR_W-1:0]    front_char;
  logic [cdeq_pkg::CHAR_W-1:0]    back_char;
  logic [cdeq_pkg::COUNT_W-1:0]   count;
  logic                           is_empty;

  // The controller sequences each command and owns both handshakes.
  cdeq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid_i),
    .s_tready_o (s_axis_tready_o),
    .m_tvalid_o (m_axis_tvalid_o),
    .m_tready_i (m_axis_tready_i),
    .dp_cmd_o   (dp_cmd)
  );

  // The datapath holds the ring buffer, its pointers and the result register.
  cdeq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dp_cmd_i     (dp_cmd),
    .command_i    (s_axis_tdata_i[CMD_LO +: cdeq_pkg::CMD_W]),
    .char_in_i    (s_axis_tdata_i[CHAR_LO +: cdeq_pkg::CHAR_W]),
    .status_o     (status),
    .front_char_o (front_char),
    .back_char_o  (back_char),
    .count_o      (count),
    .is_empty_o   (is_empty)
  );

  always_comb begin
    m_axis_tdata_o = '0;
    m_axis_tdata_o[ST_LO +: cdeq_pkg::STATUS_W]   = status;
    m_axis_tdata_o[FRONT_LO +: cdeq_pkg::CHAR_W]  = front_char;
    m_axis_tdata_o[BACK_LO +: cdeq_pkg::CHAR_W]   = back_char;
    m_axis_tdata_o[COUNT_LO +: cdeq_pkg::COUNT_W] = count;
    m_axis_tdata_o[EMPTY_LO]                      = is_empty;
  end

endmodule

// ===== hdl/cdeq_checker.sv =====
// ----------------------------------------------------------------------------
// cdeq_checker: port-level checks for the character deque
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module cdeq_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              s_tvalid_i,
  input logic                              s_tready_i,
  input logic                              m_tvalid_i,
  input logic                              m_tready_i,
  input logic [cdeq_pkg::OUT_TDATA_W-1:0]  m_tdata_i
);

  logic [cdeq_pkg::STATUS_W-1:0] status;
  logic [cdeq_pkg::CHAR_W-1:0]   front_char;
  logic [cdeq_pkg::CHAR_W-1:0]   back_char;
  logic [cdeq_pkg::COUNT_W-1:0]  count;
  logic                          is_empty;

  assign status     = m_tdata_i[1:0];
  assign front_char = m_tdata_i[9:2];
  assign back_char  = m_tdata_i[17:10];
  assign count      = m_tdata_i[22:18];
  assign is_empty   = m_tdata_i[23];

  // A result offered but not taken stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && !m_tready_i |=> m_tvalid_i)
    else $error("result valid dropped while stalled");

  // Commands are handled one at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tvalid_i && s_tready_i |=> !s_tready_i)
    else $error("input ready right after an accepted command");

  // An empty deque shows no characters and a zero count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && is_empty |-> count == '0 && front_char == '0 && back_char == '0)
    else $error("empty result with nonzero fields");

  // An empty status only comes from a deque that is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_i && status == cdeq_pkg::ST_EMPTY |-> is_empty)
    else $error("empty status on a non-empty deque");

endmodule

bind char_double_ended_queue_top cdeq_checker u_cdeq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .s_tvalid_i (s_axis_tvalid_i),
  .s_tready_i (s_axis_tready_o),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o)
);

// ===== dv/char_double_ended_queue_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// char_double_ended_queue_top_tb: self-checking bench for the character deque
// A short table of hand-picked commands is followed by a long run of
// random command sequences driving the fill to empty, full and mid levels. An
// in-bench model of the deque predicts every result request, and each
// request taken from the master stream is checked field by field.
// ----------------------------------------------------------------------------
module char_double_ended_queue_top_tb;

  localparam int unsigned DQ_DEPTH = cdeq_pkg::DEPTH_DEFAULT;
  localparam int unsigned OP_W     = cdeq_pkg::CMD_W;
  // Command codes the block does not define; it must handle them as a peek.
  localparam logic [OP_W-1:0] CMD_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] CMD_SPARE_7 = 3'd7;
  localparam int unsigned RANDOM_PER_PHASE = 600;
  localparam int unsigned DRAIN_CYCLES     = 16;
  localparam int unsigned CYCLE_LIMIT      = 200000;

  // The member order mirrors the master tdata layout, top bit first, so a
  // result request can be read straight off the bus.
  typedef struct packed {
    logic              is_empty;
    logic [4:0]        count;
    logic [7:0]        back_char;
    logic [7:0]        front_char;
    cdeq_pkg::status_e status;
  } deque_result_t;

  // One row of the directed table. The row is sent reps times, with the
  // character stepping up by one each time. Where known is set, the typed
  // result is the expectation; otherwise the model supplies it.
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [7:0]      ch;
    int              reps;
    bit              known;
    deque_result_t   res;
  } stim_row_t;

  localparam deque_result_t EMPTY_NO_OP =
    '{is_empty: 1'b1, count: 5'd0, back_char: 8'h00, front_char: 8'h00,
      status: cdeq_pkg::ST_EMPTY};
  localparam deque_result_t EMPTY_OK =
    '{is_empty: 1'b1, count: 5'd0, back_char: 8'h00, front_char: 8'h00,
      status: cdeq_pkg::ST_OK};
  localparam deque_result_t ANY = EMPTY_OK;

  localparam int NROWS = 20;
  stim_row_t cmd_table [NROWS] = '{
    // Freshly reset: peeking and popping either end find nothing.
    '{op: cdeq_pkg::CMD_PEEK,       ch: 8'h00, reps: 1,  known: 1'b1, res: EMPTY_NO_OP},
    '{op: cdeq_pkg::CMD_POP_FRONT,  ch: 8'hFF, reps: 1,  known: 1'b1, res: EMPTY_NO_OP},
    '{op: cdeq_pkg::CMD_POP_BACK,   ch: 8'hFF, reps: 1,  known: 1'b1, res: EMPTY_NO_OP},
    // Character extremes at each end.
    '{op: cdeq_pkg::CMD_PUSH_FRONT, ch: 8'hFF, reps: 1,  known: 1'b1,
      res: '{is_empty: 1'b0, count: 5'd1, back_char: 8'hFF, front_char: 8'hFF,
             status: cdeq_pkg::ST_OK}},
    '{op: cdeq_pkg::CMD_PUSH_BACK,  ch: 8'h00, reps: 1,  known: 1'b1,
      res: '{is_empty: 1'b0, count: 5'd2, back_char: 8'h00, front_char: 8'hFF,
             status: cdeq_pkg::ST_OK}},
    '{op: cdeq_pkg::CMD_PEEK,       ch: 8'h5A, reps: 1,  known: 1'b0, res: ANY},
    '{op: cdeq_pkg::CMD_POP_FRONT,  ch: 8'h00, reps: 1,  known: 1'b0, res: ANY},
    // Taking the last character from the back must leave the deque empty.
    '{op: cdeq_pkg::CMD_POP_BACK,   ch: 8'h00, reps: 1,  known: 1'b1, res: EMPTY_OK},
    '{op: cdeq_pkg::CMD_PUSH_BACK,  ch: 8'hA5, reps: 1,  known: 1'b0, res: ANY},
    // Same from the front.
    '{op: cdeq_pkg::CMD_POP_FRONT,  ch: 8'h00, reps: 1,  known: 1'b1, res: EMPTY_OK},
    '{op: cdeq_pkg::CMD_CLEAR,      ch: 8'h00, reps: 1,  known: 1'b1, res: EMPTY_OK},
    // Fill completely from the front, so the head wraps below slot zero.
    '{op: cdeq_pkg::CMD_PUSH_FRONT, ch: 8'h10, reps: DQ_DEPTH, known: 1'b0, res: ANY},
    // Pushes on a full deque are dropped.
    '{op: cdeq_pkg::CMD_PUSH_FRONT, ch: 8'hEE, reps: 1,  known: 1'b0, res: ANY},
    '{op: cdeq_pkg::CMD_PUSH_BACK,  ch: 8'hDD, reps: 1,  known: 1'b0, res: ANY},
    // Undefined codes behave like a peek.
    '{op: CMD_SPARE_6,              ch: 8'h81, reps: 1,  known: 1'b0, res: ANY},
    '{op: CMD_SPARE_7,              ch: 8'h7E, reps: 1,  known: 1'b0, res: ANY},
    // Drain the full deque from both ends, then clear a non-empty one.
    '{op: cdeq_pkg::CMD_POP_BACK,   ch: 8'h00, reps: DQ_DEPTH / 2, known: 1'b0, res: ANY},
    '{op: cdeq_pkg::CMD_POP_FRONT,  ch: 8'h00, reps: DQ_DEPTH / 2 - 1, known: 1'b0,
      res: ANY},
    '{op: cdeq_pkg::CMD_PUSH_FRONT, ch: 8'hC3, reps: 1,  known: 1'b0, res: ANY},
    '{op: cdeq_pkg::CMD_CLEAR,      ch: 8'h00, reps: 1,  known: 1'b1, res: EMPTY_OK}
  };

  // --------------------------------------------------------------------------
  // Clock, reset and the block's ports. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic                             clk_i   = 1'b0;
  logic                             rst_ni  = 1'b0;
  logic                             s_valid = 1'b0;
  logic [cdeq_pkg::IN_TDATA_W-1:0]  s_data  = '0;
  logic                             m_ready = 1'b0;
  logic                             s_axis_tready_o;
  logic                             m_axis_tvalid_o;
  logic [cdeq_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  char_double_ended_queue_top #(
    .DEPTH(DQ_DEPTH)
  ) DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // --------------------------------------------------------------------------
  // Deque model. Its state moves forward only when a command request is
  // accepted, so it always describes the deque the next command will see.
  // --------------------------------------------------------------------------
  logic [7:0]    model_slots [DQ_DEPTH];
  int            model_head = 0;
  int            model_fill = 0;
  deque_result_t pending_results [$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int mismatches  = 0;
  int n_results   = 0;
  int n_dropped   = 0;
  int n_on_empty  = 0;
  int n_emptied   = 0;
  int cycle_count = 0;

  function automatic deque_result_t deque_apply(logic [OP_W-1:0] op, logic [7:0] ch);
    deque_result_t r;
    r = '{is_empty: 1'b0, count: 5'd0, back_char: 8'h00, front_char: 8'h00,
          status: cdeq_pkg::ST_OK};
    case (op)
      cdeq_pkg::CMD_PUSH_FRONT: begin
        if (model_fill == DQ_DEPTH) begin
          r.status = cdeq_pkg::ST_FULL;
        end else begin
          model_head = (model_head + DQ_DEPTH - 1) % DQ_DEPTH;
          model_slots[model_head] = ch;
          model_fill++;
        end
      end
      cdeq_pkg::CMD_PUSH_BACK: begin
        if (model_fill == DQ_DEPTH) begin
          r.status = cdeq_pkg::ST_FULL;
        end else begin
          model_slots[(model_head + model_fill) % DQ_DEPTH] = ch;
          model_fill++;
        end
      end
      cdeq_pkg::CMD_POP_FRONT: begin
        if (model_fill == 0) begin
          r.status = cdeq_pkg::ST_EMPTY;
        end else begin
          model_head = (model_head + 1) % DQ_DEPTH;
          model_fill--;
        end
      end
      cdeq_pkg::CMD_POP_BACK: begin
        if (model_fill == 0) begin
          r.status = cdeq_pkg::ST_EMPTY;
        end else begin
          model_fill--;
        end
      end
      cdeq_pkg::CMD_CLEAR: begin
        model_fill = 0;
        model_head = 0;
      end
      default: begin
        // Peek and the two undefined codes only report.
        if (model_fill == 0) r.status = cdeq_pkg::ST_EMPTY;
      end
    endcase
    if (model_fill != 0) begin
      r.front_char = model_slots[model_head];
      r.back_char  = model_slots[(model_head + model_fill - 1) % DQ_DEPTH];
    end
    r.count    = model_fill[4:0];
    r.is_empty = (model_fill == 0);
    return r;
  endfunction

  // Offers one command request, with random idle cycles in front of it, and
  // files the expected result once the block has taken it. The valid line is
  // written at most once per clock edge.
  task automatic send_command(input logic [OP_W-1:0] op, input logic [7:0] ch,
                              input bit known, input deque_result_t typed);
    deque_result_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_valid <= 1'b0;
      @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {{(cdeq_pkg::IN_TDATA_W - cdeq_pkg::IN_W){1'b0}}, ch, op};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    predicted = deque_apply(op, ch);
    pending_results.push_back(known ? typed : predicted);
  endtask

  // Picks a command that pulls the fill level toward a target. A target of
  // zero keeps popping an empty deque, a target of DEPTH keeps pushing a
  // full one, and a share of noise keeps every code in play.
  function automatic logic [OP_W-1:0] pick_command(int target);
    int roll;
    roll = $urandom_range(99);
    if (roll < 2) return cdeq_pkg::CMD_CLEAR;
    if (roll < 5) return cdeq_pkg::CMD_PEEK;
    if (roll < 7) return ($urandom_range(1) != 0) ? CMD_SPARE_6 : CMD_SPARE_7;
    if (roll < 20) return OP_W'($urandom_range(cdeq_pkg::CMD_POP_BACK));
    if (model_fill < target || target == DQ_DEPTH)
      return ($urandom_range(1) != 0) ? cdeq_pkg::CMD_PUSH_FRONT : cdeq_pkg::CMD_PUSH_BACK;
    return ($urandom_range(1) != 0) ? cdeq_pkg::CMD_POP_FRONT : cdeq_pkg::CMD_POP_BACK;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] seen);
    if (seen !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, seen);
      mismatches++;
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: each accepted result request is checked against the oldest
  // expectation, then the ready line is redrawn for the next edge.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    deque_result_t got;
    deque_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      got = deque_result_t'(m_axis_tdata_o[cdeq_pkg::OUT_W-1:0]);
      n_results++;
      if (got.status == cdeq_pkg::ST_FULL) n_dropped++;
      if (got.status == cdeq_pkg::ST_EMPTY) n_on_empty++;
      if (got.is_empty === 1'b1 && got.status == cdeq_pkg::ST_OK) n_emptied++;
      if (pending_results.size() == 0) begin
        $display("%0t: result request with nothing expected, got %h", $time, got);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("status",     8'(want.status),   8'(got.status));
        check_field("front_char", want.front_char,   got.front_char);
        check_field("back_char",  want.back_char,    got.back_char);
        check_field("count",      8'(want.count),    8'(got.count));
        check_field("is_empty",   8'(want.is_empty), 8'(got.is_empty));
      end
    end
    m_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // Watchdog: a hung handshake ends the run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, pending_results.size());
      $display("simulation failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: reset, the directed table, then three random phases with
  // different idling on each side.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int target;
    logic [OP_W-1:0] op;
    for (int i = 0; i < DQ_DEPTH; i++) model_slots[i] = 8'h00;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Phase one: the sender rarely idles, the receiver often stalls.
    tx_idle_pct = 14;
    rx_idle_pct = 64;
    foreach (cmd_table[r]) begin
      for (int k = 0; k < cmd_table[r].reps; k++) begin
        send_command(cmd_table[r].op, cmd_table[r].ch + 8'(k),
                     cmd_table[r].known, cmd_table[r].res);
      end
    end

    target = 0;
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        tx_idle_pct = 64;
        rx_idle_pct = 14;
      end else if (phase == 2) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        // Every so often aim at a new fill level: empty, full or in between.
        if ($urandom_range(29) == 0) begin
          case ($urandom_range(2))
            0:       target = 0;
            1:       target = DQ_DEPTH;
            default: target = $urandom_range(DQ_DEPTH - 1, 1);
          endcase
        end
        op = pick_command(target);
        send_command(op, 8'($urandom_range(255)), 1'b0, ANY);
      end
    end
    s_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("checked %0d result requests over %0d cycles", n_results, cycle_count);
    $display("pushes dropped on full: %0d, pops or peeks on empty: %0d, emptied: %0d",
             n_dropped, n_on_empty, n_emptied);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d results never seen", mismatches,
               pending_results.size());
      $display("simulation failed");
    end
    $finish;
  end

endmodule
